// ----- rtl/ipsq_pkg.sv -----
// ----------------------------------------------------------------------------
// ipsq_pkg
// shared types, codes and constants of the i2c packet sequencer
// ----------------------------------------------------------------------------
package ipsq_pkg;

    localparam int TX_DEPTH_DEF = 64;

    localparam logic [2:0] OP_STATUS  = 3'd0;
    localparam logic [2:0] OP_LOAD    = 3'd1;
    localparam logic [2:0] OP_SEND    = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;

    localparam logic [7:0] ST_MASK        = 8'b1111_1000;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_MT_SLA_ACK  = 8'h18;
    localparam logic [7:0] ST_MT_SLA_NACK = 8'h20;
    localparam logic [7:0] ST_MT_DAT_ACK  = 8'h28;
    localparam logic [7:0] ST_MT_DAT_NACK = 8'h30;
    localparam logic [7:0] ST_ARB_LOST    = 8'h38;
    localparam logic [7:0] ST_MR_SLA_ACK  = 8'h40;
    localparam logic [7:0] ST_MR_SLA_NACK = 8'h48;
    localparam logic [7:0] ST_MR_DAT_ACK  = 8'h50;
    localparam logic [7:0] ST_MR_DAT_NACK = 8'h58;
    localparam logic [7:0] ST_SR_SLA_ACK  = 8'h60;
    localparam logic [7:0] ST_SR_ARB_LOST = 8'h68;
    localparam logic [7:0] ST_SR_GC_LOST  = 8'h78;
    localparam logic [7:0] ST_SR_DAT_ACK  = 8'h80;
    localparam logic [7:0] ST_SR_DAT_NACK = 8'h88;
    localparam logic [7:0] ST_SR_STOP     = 8'hA0;

    localparam logic [1:0] EV_NONE      = 2'd0;
    localparam logic [1:0] EV_SEND_DONE = 2'd1;
    localparam logic [1:0] EV_SLAVE_PKT = 2'd2;
    localparam logic [1:0] EV_READ_DONE = 2'd3;

    localparam logic [0:0] CFG_SLAVE_ENABLE   = 1'd0;
    localparam logic [0:0] CFG_SLAVE_CAPACITY = 1'd1;

    localparam logic [3:0] CTL_CLR_INT = 4'b0001;
    localparam logic [3:0] CTL_ACK     = 4'b0010;
    localparam logic [3:0] CTL_START   = 4'b0100;
    localparam logic [3:0] CTL_STOP    = 4'b1000;

    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] status_code;
        logic [7:0] data_byte;
        logic [6:0] peer_address;
        logic [7:0] count;
        logic [5:0] buffer_index;
    } cmd_t;

    typedef struct packed {
        logic       control_write;
        logic [3:0] control_bits;
        logic       data_write;
        logic [7:0] data_value;
        logic       store_write;
        logic       store_target;
        logic [7:0] store_index;
        logic [7:0] store_byte;
        logic [1:0] event_res;
        logic [7:0] event_length;
    } res_t;

    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic [7:0] raddr;
    } txbuf_req_t;

endpackage

// ----- rtl/ipsq_if.sv -----
// ----------------------------------------------------------------------------
// ipsq_if
// command and result channels of the i2c packet sequencer
// ----------------------------------------------------------------------------
interface ipsq_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] status_code;
    logic [7:0] data_byte;
    logic [6:0] peer_address;
    logic [7:0] count;
    logic [5:0] buffer_index;

    modport source (output valid, opcode, status_code, data_byte, peer_address,
                    count, buffer_index, input ready);
    modport sink (input valid, opcode, status_code, data_byte, peer_address,
                  count, buffer_index, output ready);
endinterface

interface ipsq_res_if;
    logic       valid;
    logic       ready;
    logic       control_write;
    logic [3:0] control_bits;
    logic       data_write;
    logic [7:0] data_value;
    logic       store_write;
    logic       store_target;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic [1:0] event_res;
    logic [7:0] event_length;

    modport source (output valid, control_write, control_bits, data_write, data_value,
                    store_write, store_target, store_index, store_byte, event_res,
                    event_length, input ready);
    modport sink (input valid, control_write, control_bits, data_write, data_value,
                  store_write, store_target, store_index, store_byte, event_res,
                  event_length, output ready);
endinterface

// ----- rtl/i2c_packet_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// i2c_packet_sequencer_unit
// packet sequencer on top of an i2c byte engine, taking (when not stalled) one command beat per cycle
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  cmd       in    valid / ready    opcode, status_code, data_byte, peer_address,
//                                   count, buffer_index
//  res       out   valid / ready    control and data writes, store, event
//  cfg       in    cfg_we           cfg_index, cfg_data
//
//  one beat per cycle sustained while results are taken; a command passes through the input
//  register and its result is then registered in the output register
//  the transmit buffer prefetches the byte at the send position into its read register
//  reset clears all sequencer state; the transmit buffer is not cleared
//  a stalled result holds the output register, the input register still takes one
//  more beat, then cmd.ready drops until the result is taken
// ----------------------------------------------------------------------------
module i2c_packet_sequencer_unit #(
    parameter int TX_DEPTH = ipsq_pkg::TX_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    ipsq_cmd_if.sink        cmd,
    ipsq_res_if.source      res,
    input  logic            cfg_we,
    input  logic [0:0]      cfg_index,
    input  logic [7:0]      cfg_data
);
    import ipsq_pkg::*;

    logic       in_valid_reg;
    cmd_t       in_reg;
    logic       out_valid_reg;
    res_t       out_reg;
    logic       fire;
    res_t       core_res;
    txbuf_req_t tx_req;
    logic [7:0] tx_rdata;
    logic       slave_enable_reg;
    logic [7:0] slave_capacity_reg;

    assign fire      = in_valid_reg && (!out_valid_reg || res.ready);
    assign cmd.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_enable_reg   <= 1'b0;
            slave_capacity_reg <= 8'd32;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLAVE_ENABLE:   slave_enable_reg   <= cfg_data[0];
                CFG_SLAVE_CAPACITY: slave_capacity_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                in_valid_reg <= cmd.valid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ready && cmd.valid)
        begin
            in_reg.opcode       <= cmd.opcode;
            in_reg.status_code  <= cmd.status_code;
            in_reg.data_byte    <= cmd.data_byte;
            in_reg.peer_address <= cmd.peer_address;
            in_reg.count        <= cmd.count;
            in_reg.buffer_index <= cmd.buffer_index;
        end
        if (fire)
        begin
            out_reg <= core_res;
        end
    end

    ipsq_core #(
        .TX_DEPTH(TX_DEPTH)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .cmd            (in_reg),
        .slave_enable   (slave_enable_reg),
        .slave_capacity (slave_capacity_reg),
        .tx_rdata       (tx_rdata),
        .tx_req         (tx_req),
        .res            (core_res)
    );

    ipsq_txbuf #(
        .TX_DEPTH(TX_DEPTH)
    ) u_txbuf (
        .clk   (clk),
        .req   (tx_req),
        .rdata (tx_rdata)
    );

    assign res.valid         = out_valid_reg;
    assign res.control_write = out_reg.control_write;
    assign res.control_bits  = out_reg.control_bits;
    assign res.data_write    = out_reg.data_write;
    assign res.data_value    = out_reg.data_value;
    assign res.store_write   = out_reg.store_write;
    assign res.store_target  = out_reg.store_target;
    assign res.store_index   = out_reg.store_index;
    assign res.store_byte    = out_reg.store_byte;
    assign res.event_res     = out_reg.event_res;
    assign res.event_length  = out_reg.event_length;

`ifndef ASSERT_OFF
    // every stored byte comes from a bus status beat, which always writes control
    a_store_has_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.store_write) |-> out_reg.control_write)
        else $error("store without control write");

    a_event_has_ctrl: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.event_res != EV_NONE)) |-> out_reg.control_write)
        else $error("completion event without control write");

    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && (in_reg.opcode == OP_LOAD)) |=>
            (out_valid_reg && !out_reg.control_write && !out_reg.data_write))
        else $error("transmit load produced bus activity");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (in_valid_reg && out_valid_reg && !res.ready))
        else $error("input stalled with room downstream");
`endif

endmodule

// ----- rtl/ipsq_txbuf.sv -----
// ----------------------------------------------------------------------------
// ipsq_txbuf
// transmit byte buffer with registered read of the current send position
// ----------------------------------------------------------------------------
module ipsq_txbuf #(
    parameter int TX_DEPTH = ipsq_pkg::TX_DEPTH_DEF
) (
    input  logic                    clk,
    input  ipsq_pkg::txbuf_req_t    req,
    output logic [7:0]              rdata
);
    import ipsq_pkg::*;

    localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

    logic [7:0] mem [TX_DEPTH];
    logic [7:0] rdata_reg;

    // write-first so a load of the byte about to be sent is seen at once
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
        if (req.we && (req.waddr == req.raddr))
        begin
            rdata_reg <= req.wdata;
        end
        else
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ipsq_core.sv -----
// ----------------------------------------------------------------------------
// ipsq_core
// sequencer state and the per-beat decision logic
// ----------------------------------------------------------------------------
module ipsq_core #(
    parameter int TX_DEPTH = ipsq_pkg::TX_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    fire,
    input  ipsq_pkg::cmd_t          cmd,
    input  logic                    slave_enable,
    input  logic [7:0]              slave_capacity,
    input  logic [7:0]              tx_rdata,
    output ipsq_pkg::txbuf_req_t    tx_req,
    output ipsq_pkg::res_t          res
);
    import ipsq_pkg::*;

    localparam logic [7:0] DEPTH8 = 8'(TX_DEPTH);

    logic       bus_owned_reg, bus_owned_next;
    logic       suppress_ack_reg, suppress_ack_next;
    logic       send_pending_reg, send_pending_next;
    logic [6:0] send_dest_reg, send_dest_next;
    logic [7:0] send_length_reg, send_length_next;
    logic [7:0] send_position_reg, send_position_next;
    logic       slave_active_reg, slave_active_next;
    logic [7:0] slave_count_reg, slave_count_next;
    logic       slave_busy_reg, slave_busy_next;
    logic       read_pending_reg, read_pending_next;
    logic [6:0] read_dest_reg, read_dest_next;
    logic [7:0] read_capacity_reg, read_capacity_next;
    logic [7:0] read_count_reg, read_count_next;

    logic       do_ctrl;
    logic [3:0] ctrl_bits;
    logic       bus_wanted;
    logic [7:0] masked;

    always_comb
    begin
        bus_owned_next     = bus_owned_reg;
        suppress_ack_next  = suppress_ack_reg;
        send_pending_next  = send_pending_reg;
        send_dest_next     = send_dest_reg;
        send_length_next   = send_length_reg;
        send_position_next = send_position_reg;
        slave_active_next  = slave_active_reg;
        slave_count_next   = slave_count_reg;
        slave_busy_next    = slave_busy_reg;
        read_pending_next  = read_pending_reg;
        read_dest_next     = read_dest_reg;
        read_capacity_next = read_capacity_reg;
        read_count_next    = read_count_reg;
        res        = '0;
        do_ctrl    = 1'b0;
        ctrl_bits  = 4'd0;
        bus_wanted = 1'b0;
        masked     = cmd.status_code & ST_MASK;
        tx_req.we    = 1'b0;
        tx_req.waddr = {2'b00, cmd.buffer_index};
        tx_req.wdata = cmd.data_byte;

        unique case (cmd.opcode)
            OP_STATUS:
            begin
                do_ctrl   = 1'b1;
                ctrl_bits = CTL_CLR_INT;
                case (masked)
                    ST_START, ST_RESTART:
                    begin
                        if (send_pending_reg)
                        begin
                            res.data_write     = 1'b1;
                            res.data_value     = {send_dest_reg, 1'b0};
                            send_position_next = 8'd0;
                            bus_owned_next     = 1'b1;
                        end
                        else if (read_pending_reg)
                        begin
                            res.data_write  = 1'b1;
                            res.data_value  = {read_dest_reg, 1'b1};
                            read_count_next = 8'd0;
                            bus_owned_next  = 1'b1;
                        end
                    end
                    ST_MT_SLA_NACK, ST_MT_DAT_NACK:
                    begin
                        if (send_pending_reg)
                        begin
                            send_pending_next = 1'b0;
                            res.event_res     = EV_SEND_DONE;
                        end
                    end
                    ST_ARB_LOST, ST_SR_GC_LOST:
                    begin
                        bus_owned_next = 1'b0;
                    end
                    ST_MT_SLA_ACK, ST_MT_DAT_ACK:
                    begin
                        if (send_pending_reg)
                        begin
                            if (send_position_reg >= send_length_reg)
                            begin
                                send_pending_next = 1'b0;
                                res.event_res     = EV_SEND_DONE;
                            end
                            else
                            begin
                                res.data_write     = 1'b1;
                                res.data_value     = tx_rdata;
                                send_position_next = send_position_reg + 8'd1;
                            end
                        end
                    end
                    ST_SR_SLA_ACK, ST_SR_ARB_LOST:
                    begin
                        if (masked == ST_SR_ARB_LOST)
                        begin
                            bus_owned_next = 1'b0;
                        end
                        if (slave_enable && !slave_busy_reg && !slave_active_reg)
                        begin
                            slave_active_next = 1'b1;
                            slave_count_next  = 8'd0;
                        end
                        else
                        begin
                            slave_active_next = 1'b0;
                            suppress_ack_next = 1'b1;
                        end
                    end
                    ST_SR_DAT_ACK:
                    begin
                        if (!slave_active_reg)
                        begin
                            suppress_ack_next = 1'b1;
                        end
                        else if (slave_capacity <= slave_count_reg)
                        begin
                            slave_active_next = 1'b0;
                            slave_busy_next   = 1'b0;
                            suppress_ack_next = 1'b1;
                        end
                        else
                        begin
                            res.store_write  = 1'b1;
                            res.store_target = 1'b0;
                            res.store_index  = slave_count_reg;
                            res.store_byte   = cmd.data_byte;
                            slave_count_next = slave_count_reg + 8'd1;
                        end
                    end
                    ST_SR_DAT_NACK:
                    begin
                        if (slave_active_reg)
                        begin
                            slave_active_next = 1'b0;
                            slave_busy_next   = 1'b0;
                        end
                    end
                    ST_SR_STOP:
                    begin
                        if (slave_active_reg && (slave_count_reg != 8'd0))
                        begin
                            slave_busy_next  = 1'b1;
                            res.event_res    = EV_SLAVE_PKT;
                            res.event_length = slave_count_reg;
                        end
                        slave_active_next = 1'b0;
                    end
                    ST_MR_SLA_ACK:
                    begin
                        if (read_pending_reg
                            && ({1'b0, read_count_reg} + 9'd1 == {1'b0, read_capacity_reg}))
                        begin
                            suppress_ack_next = 1'b1;
                        end
                    end
                    ST_MR_DAT_ACK, ST_MR_DAT_NACK:
                    begin
                        if (read_pending_reg && (read_count_reg < read_capacity_reg))
                        begin
                            res.store_write  = 1'b1;
                            res.store_target = 1'b1;
                            res.store_index  = read_count_reg;
                            res.store_byte   = cmd.data_byte;
                            read_count_next  = read_count_reg + 8'd1;
                            if ({1'b0, read_count_next} + 9'd1 == {1'b0, read_capacity_reg})
                            begin
                                suppress_ack_next = 1'b1;
                            end
                            if (read_count_next == read_capacity_reg)
                            begin
                                read_pending_next = 1'b0;
                                res.event_res     = EV_READ_DONE;
                                res.event_length  = read_count_next;
                            end
                        end
                    end
                    ST_MR_SLA_NACK:
                    begin
                        if (read_pending_reg)
                        begin
                            read_pending_next = 1'b0;
                            res.event_res     = EV_READ_DONE;
                            res.event_length  = read_count_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_LOAD:
            begin
                tx_req.we = ({2'b00, cmd.buffer_index} < DEPTH8);
            end
            OP_SEND:
            begin
                if (!send_pending_reg)
                begin
                    send_pending_next = 1'b1;
                    send_dest_next    = cmd.peer_address;
                    send_length_next  = (cmd.count > DEPTH8) ? DEPTH8 : cmd.count;
                    do_ctrl           = 1'b1;
                end
            end
            OP_READ:
            begin
                if (!read_pending_reg)
                begin
                    read_pending_next  = 1'b1;
                    read_dest_next     = cmd.peer_address;
                    read_capacity_next = cmd.count;
                    do_ctrl            = 1'b1;
                end
            end
            OP_RELEASE:
            begin
                slave_busy_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        // control register write uses the state left by the command
        if (do_ctrl)
        begin
            bus_wanted = send_pending_next || read_pending_next;
            if (!suppress_ack_next)
            begin
                ctrl_bits = ctrl_bits | CTL_ACK;
            end
            suppress_ack_next = 1'b0;
            if (bus_wanted && !bus_owned_next)
            begin
                ctrl_bits = ctrl_bits | CTL_START;
            end
            if (!bus_wanted && bus_owned_next)
            begin
                ctrl_bits      = ctrl_bits | CTL_STOP;
                bus_owned_next = 1'b0;
            end
            res.control_write = 1'b1;
            res.control_bits  = ctrl_bits;
        end

        tx_req.we    = tx_req.we && fire;
        tx_req.raddr = fire ? send_position_next : send_position_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_owned_reg     <= 1'b0;
            suppress_ack_reg  <= 1'b0;
            send_pending_reg  <= 1'b0;
            send_dest_reg     <= 7'd0;
            send_length_reg   <= 8'd0;
            send_position_reg <= 8'd0;
            slave_active_reg  <= 1'b0;
            slave_count_reg   <= 8'd0;
            slave_busy_reg    <= 1'b0;
            read_pending_reg  <= 1'b0;
            read_dest_reg     <= 7'd0;
            read_capacity_reg <= 8'd0;
            read_count_reg    <= 8'd0;
        end
        else if (fire)
        begin
            bus_owned_reg     <= bus_owned_next;
            suppress_ack_reg  <= suppress_ack_next;
            send_pending_reg  <= send_pending_next;
            send_dest_reg     <= send_dest_next;
            send_length_reg   <= send_length_next;
            send_position_reg <= send_position_next;
            slave_active_reg  <= slave_active_next;
            slave_count_reg   <= slave_count_next;
            slave_busy_reg    <= slave_busy_next;
            read_pending_reg  <= read_pending_next;
            read_dest_reg     <= read_dest_next;
            read_capacity_reg <= read_capacity_next;
            read_count_reg    <= read_count_next;
        end
    end

endmodule

// ----- tb/i2c_packet_sequencer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_packet_sequencer_unit_tb
// drives command beats into the packet sequencer, predicts every result beat
// from a local copy of the sequencer state and compares them field by field;
// directed checks first, then randomized send, read and slave receive
// transactions mixed with noise over several register settings
// ----------------------------------------------------------------------------
module i2c_packet_sequencer_unit_tb;

    import ipsq_pkg::*;

    localparam int         TXD        = TX_DEPTH_DEF;
    localparam logic [7:0] TXD_LEN    = 8'(TXD);
    localparam logic [7:0] ST_UNLISTED = 8'hF8;
    localparam logic [2:0] OP_BAD     = 3'd7;
    localparam int         PHASE_BEATS = 200;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [0:0] cfg_index;
    logic [7:0] cfg_data;

    ipsq_cmd_if cmd_ch ();
    ipsq_res_if res_ch ();

    i2c_packet_sequencer_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the sequencer state
    logic       own_bus, hold_nack;
    logic       tx_busy, rx_open, rx_full, rd_busy;
    logic [6:0] tx_dest, rd_dest;
    logic [7:0] tx_len, tx_pos, rx_cnt, rd_cap, rd_cnt;
    logic [7:0] tx_mem [0:TXD-1];
    logic       slave_en_cfg;
    logic [7:0] slave_cap_cfg;
    res_t       next_act;

    res_t pending_actions [$];
    res_t got_act, want_act;

    bit src_idle_on;
    bit sink_stall_on;
    int stall_left;
    int beats_sent;
    int results_seen;
    int mismatches;
    int settings_used;
    int send_seqs, read_seqs, slave_seqs, noise_seqs;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("i2c_packet_sequencer_unit_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void drive_control(input logic [3:0] bits);
        logic       need;
        logic [3:0] b;
        need = tx_busy || rd_busy;
        b = bits;
        if (!hold_nack)
            b = b | CTL_ACK;
        hold_nack = 1'b0;
        if (need && !own_bus)
            b = b | CTL_START;
        if (!need && own_bus)
        begin
            b = b | CTL_STOP;
            own_bus = 1'b0;
        end
        next_act.control_write = 1'b1;
        next_act.control_bits = b;
    endfunction

    function automatic void close_send();
        if (tx_busy)
        begin
            tx_busy = 1'b0;
            next_act.event_res = EV_SEND_DONE;
        end
    endfunction

    function automatic void close_read();
        if (rd_busy)
        begin
            rd_busy = 1'b0;
            next_act.event_res = EV_READ_DONE;
            next_act.event_length = rd_cnt;
        end
    endfunction

    function automatic void mark_last_read();
        if (rd_busy && ({1'b0, rd_cnt} + 9'd1 == {1'b0, rd_cap}))
            hold_nack = 1'b1;
    endfunction

    function automatic void run_bus_event(input logic [7:0] st, input logic [7:0] b);
        case (st)
            ST_START, ST_RESTART:
            begin
                if (tx_busy)
                begin
                    next_act.data_write = 1'b1;
                    next_act.data_value = {tx_dest, 1'b0};
                    tx_pos = 8'd0;
                    own_bus = 1'b1;
                end
                else if (rd_busy)
                begin
                    next_act.data_write = 1'b1;
                    next_act.data_value = {rd_dest, 1'b1};
                    rd_cnt = 8'd0;
                    own_bus = 1'b1;
                end
            end
            ST_MT_SLA_NACK, ST_MT_DAT_NACK:
                close_send();
            ST_ARB_LOST, ST_SR_GC_LOST:
                own_bus = 1'b0;
            ST_MT_SLA_ACK, ST_MT_DAT_ACK:
            begin
                if (tx_busy)
                begin
                    if (tx_pos >= tx_len)
                        close_send();
                    else
                    begin
                        next_act.data_write = 1'b1;
                        next_act.data_value = (tx_pos < TXD_LEN) ? tx_mem[tx_pos[5:0]] : 8'h00;
                        tx_pos = tx_pos + 8'd1;
                    end
                end
            end
            ST_SR_ARB_LOST, ST_SR_SLA_ACK:
            begin
                if (st == ST_SR_ARB_LOST)
                    own_bus = 1'b0;
                if (slave_en_cfg && !rx_full && !rx_open)
                begin
                    rx_open = 1'b1;
                    rx_cnt = 8'd0;
                end
                else
                begin
                    rx_open = 1'b0;
                    hold_nack = 1'b1;
                end
            end
            ST_SR_DAT_ACK:
            begin
                if (!rx_open)
                    hold_nack = 1'b1;
                else if (slave_cap_cfg <= rx_cnt)
                begin
                    rx_open = 1'b0;
                    rx_full = 1'b0;
                    hold_nack = 1'b1;
                end
                else
                begin
                    next_act.store_write = 1'b1;
                    next_act.store_target = 1'b0;
                    next_act.store_index = rx_cnt;
                    next_act.store_byte = b;
                    rx_cnt = rx_cnt + 8'd1;
                end
            end
            ST_SR_DAT_NACK:
            begin
                if (rx_open)
                begin
                    rx_open = 1'b0;
                    rx_full = 1'b0;
                end
            end
            ST_SR_STOP:
            begin
                if (rx_open && rx_cnt > 8'd0)
                begin
                    rx_full = 1'b1;
                    next_act.event_res = EV_SLAVE_PKT;
                    next_act.event_length = rx_cnt;
                end
                rx_open = 1'b0;
            end
            ST_MR_SLA_ACK:
                mark_last_read();
            ST_MR_DAT_ACK, ST_MR_DAT_NACK:
            begin
                if (rd_busy && rd_cnt < rd_cap)
                begin
                    next_act.store_write = 1'b1;
                    next_act.store_target = 1'b1;
                    next_act.store_index = rd_cnt;
                    next_act.store_byte = b;
                    rd_cnt = rd_cnt + 8'd1;
                    mark_last_read();
                    if (rd_cnt == rd_cap)
                        close_read();
                end
            end
            ST_MR_SLA_NACK:
                close_read();
            default:
                ;
        endcase
        drive_control(CTL_CLR_INT);
    endfunction

    function automatic res_t sequence_command(input cmd_t c);
        next_act = '0;
        case (c.opcode)
            OP_STATUS:
                run_bus_event(c.status_code & ST_MASK, c.data_byte);
            OP_LOAD:
                if (c.buffer_index < TXD)
                    tx_mem[c.buffer_index] = c.data_byte;
            OP_SEND:
            begin
                if (!tx_busy)
                begin
                    tx_busy = 1'b1;
                    tx_dest = c.peer_address;
                    tx_len = (c.count > TXD_LEN) ? TXD_LEN : c.count;
                    drive_control(4'b0000);
                end
            end
            OP_READ:
            begin
                if (!rd_busy)
                begin
                    rd_busy = 1'b1;
                    rd_dest = c.peer_address;
                    rd_cap = c.count;
                    drive_control(4'b0000);
                end
            end
            OP_RELEASE:
                rx_full = 1'b0;
            default:
                ;
        endcase
        return next_act;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------
    task automatic issue_command(input cmd_t c);
        int gap;
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 10);
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.opcode       <= c.opcode;
        cmd_ch.status_code  <= c.status_code;
        cmd_ch.data_byte    <= c.data_byte;
        cmd_ch.peer_address <= c.peer_address;
        cmd_ch.count        <= c.count;
        cmd_ch.buffer_index <= c.buffer_index;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_actions.push_back(sequence_command(c));
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic random_command();
        cmd_t c;
        c.opcode = 3'($urandom_range(0, 7));
        c.status_code = 8'($urandom);
        c.data_byte = 8'($urandom);
        c.peer_address = 7'($urandom);
        c.count = 8'($urandom);
        c.buffer_index = 6'($urandom);
        issue_command(c);
    endtask

    task automatic issue_op(input logic [2:0] op, input logic [6:0] addr, input logic [7:0] cnt,
                            input logic [5:0] idx, input logic [7:0] b);
        cmd_t c;
        c.opcode = op;
        c.status_code = 8'($urandom);
        c.data_byte = b;
        c.peer_address = addr;
        c.count = cnt;
        c.buffer_index = idx;
        issue_command(c);
    endtask

    task automatic bus_status(input logic [7:0] code, input logic [7:0] b);
        cmd_t       c;
        logic [2:0] lo;
        lo = 3'($urandom_range(0, 7));
        c.opcode = OP_STATUS;
        c.status_code = code | {5'd0, lo};
        c.data_byte = b;
        c.peer_address = 7'($urandom);
        c.count = 8'($urandom);
        c.buffer_index = 6'($urandom);
        issue_command(c);
    endtask

    task automatic load_byte(input logic [5:0] idx, input logic [7:0] b);
        issue_op(OP_LOAD, 7'($urandom), 8'($urandom), idx, b);
    endtask

    task automatic request_send(input logic [6:0] addr, input logic [7:0] len);
        issue_op(OP_SEND, addr, len, 6'($urandom), 8'($urandom));
    endtask

    task automatic request_read(input logic [6:0] addr, input logic [7:0] cap);
        issue_op(OP_READ, addr, cap, 6'($urandom), 8'($urandom));
    endtask

    task automatic release_slave();
        issue_op(OP_RELEASE, 7'($urandom), 8'($urandom), 6'($urandom), 8'($urandom));
    endtask

    task automatic wait_results_drained();
        cmd_ch.valid <= 1'b0;
        while (pending_actions.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_SLAVE_ENABLE)
            slave_en_cfg = val[0];
        else
            slave_cap_cfg = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial
    begin
        res_ch.ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_stall_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 10) - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t %s", $time, what);
            $display("  expected cw=%0d cb=%h dw=%0d dv=%h sw=%0d st=%0d si=%0d sb=%h ev=%0d el=%0d",
                     want_act.control_write, want_act.control_bits, want_act.data_write,
                     want_act.data_value, want_act.store_write, want_act.store_target,
                     want_act.store_index, want_act.store_byte, want_act.event_res,
                     want_act.event_length);
            $display("  actual   cw=%0d cb=%h dw=%0d dv=%h sw=%0d st=%0d si=%0d sb=%h ev=%0d el=%0d",
                     got_act.control_write, got_act.control_bits, got_act.data_write,
                     got_act.data_value, got_act.store_write, got_act.store_target,
                     got_act.store_index, got_act.store_byte, got_act.event_res,
                     got_act.event_length);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got_act = {res_ch.control_write, res_ch.control_bits, res_ch.data_write,
                       res_ch.data_value, res_ch.store_write, res_ch.store_target,
                       res_ch.store_index, res_ch.store_byte, res_ch.event_res,
                       res_ch.event_length};
            results_seen++;
            if (pending_actions.size() == 0)
            begin
                want_act = '0;
                note_mismatch("result beat with nothing expected");
            end
            else
            begin
                want_act = pending_actions.pop_front();
                if (got_act.control_write !== want_act.control_write
                    || got_act.control_bits !== want_act.control_bits
                    || got_act.data_write !== want_act.data_write
                    || got_act.data_value !== want_act.data_value
                    || got_act.store_write !== want_act.store_write
                    || got_act.store_target !== want_act.store_target
                    || got_act.store_index !== want_act.store_index
                    || got_act.store_byte !== want_act.store_byte
                    || got_act.event_res !== want_act.event_res
                    || got_act.event_length !== want_act.event_length)
                    note_mismatch("result beat mismatch");
            end
        end
    end

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------
    task automatic test_master_send();
        load_byte(6'd0, 8'h00);
        load_byte(6'd1, 8'hFF);
        request_send(7'h7F, 8'd2);
        request_send(7'h00, 8'd5);
        bus_status(ST_START, 8'h00);
        bus_status(ST_MT_SLA_ACK, 8'hFF);
        bus_status(ST_MT_DAT_ACK, 8'h00);
        bus_status(ST_MT_DAT_ACK, 8'hFF);
    endtask

    task automatic test_send_edges();
        request_send(7'h2A, 8'd0);
        bus_status(ST_RESTART, 8'($urandom));
        bus_status(ST_MT_SLA_ACK, 8'($urandom));
        bus_status(ST_MT_DAT_ACK, 8'($urandom));
    endtask

    task automatic test_master_read();
        request_read(7'h55, 8'd2);
        request_read(7'h2A, 8'd9);
        bus_status(ST_START, 8'($urandom));
        bus_status(ST_MR_SLA_ACK, 8'($urandom));
        bus_status(ST_MR_DAT_ACK, 8'h00);
        bus_status(ST_MR_DAT_NACK, 8'hFF);
    endtask

    task automatic test_slave_receive();
        bus_status(ST_SR_SLA_ACK, 8'($urandom));
        bus_status(ST_SR_GC_LOST, 8'($urandom));
        bus_status(ST_UNLISTED, 8'($urandom));
        issue_op(OP_BAD, 7'($urandom), 8'($urandom), 6'($urandom), 8'($urandom));
        wait_results_drained();
        write_reg(CFG_SLAVE_ENABLE, 8'h01);
        write_reg(CFG_SLAVE_CAPACITY, 8'd1);
        bus_status(ST_SR_SLA_ACK, 8'($urandom));
        bus_status(ST_SR_DAT_ACK, 8'h5A);
        bus_status(ST_SR_DAT_ACK, 8'hA5);
        bus_status(ST_SR_ARB_LOST, 8'($urandom));
        bus_status(ST_SR_DAT_ACK, 8'hC3);
        bus_status(ST_SR_STOP, 8'($urandom));
        bus_status(ST_SR_SLA_ACK, 8'($urandom));
        release_slave();
    endtask

    task automatic test_fill_tx_buffer();
        int i;
        for (i = 0; i < TXD; i++)
            load_byte(i[5:0], 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // random transactions
    // ------------------------------------------------------------------
    task automatic random_send();
        int         i, n, r, len;
        logic [7:0] cnt;
        bit         broken;
        n = $urandom_range(0, 3);
        for (i = 0; i < n; i++)
            load_byte(6'($urandom), 8'($urandom));
        r = $urandom_range(0, 99);
        if (r < 80)
            cnt = 8'($urandom_range(0, 8));
        else if (r < 95)
            cnt = 8'($urandom_range(9, 64));
        else
            cnt = 8'($urandom_range(65, 255));
        len = (cnt > TXD_LEN) ? TXD : cnt;
        request_send(7'($urandom), cnt);
        bus_status($urandom_range(0, 1) ? ST_START : ST_RESTART, 8'($urandom));
        broken = ($urandom_range(0, 19) == 0);
        if (broken)
            bus_status(ST_MT_SLA_NACK, 8'($urandom));
        else
            bus_status(ST_MT_SLA_ACK, 8'($urandom));
        for (i = 0; i < len && !broken; i++)
        begin
            r = $urandom_range(0, 59);
            if (r == 0)
            begin
                bus_status(ST_MT_DAT_NACK, 8'($urandom));
                broken = 1'b1;
            end
            else if (r == 1)
            begin
                bus_status(ST_ARB_LOST, 8'($urandom));
                broken = 1'b1;
            end
            else
                bus_status(ST_MT_DAT_ACK, 8'($urandom));
        end
        send_seqs++;
    endtask

    task automatic random_read();
        int         i, r;
        logic [7:0] cap;
        bit         broken;
        r = $urandom_range(0, 99);
        if (r < 80)
            cap = 8'($urandom_range(0, 6));
        else if (r < 95)
            cap = 8'($urandom_range(7, 32));
        else
            cap = 8'($urandom_range(33, 255));
        request_read(7'($urandom), cap);
        bus_status($urandom_range(0, 1) ? ST_START : ST_RESTART, 8'($urandom));
        broken = ($urandom_range(0, 19) == 0);
        if (broken)
            bus_status(ST_MR_SLA_NACK, 8'($urandom));
        else
            bus_status(ST_MR_SLA_ACK, 8'($urandom));
        if (!broken && cap == 8'd0)
        begin
            if ($urandom_range(0, 1))
                bus_status(ST_MR_DAT_ACK, 8'($urandom));
            bus_status(ST_MR_SLA_NACK, 8'($urandom));
        end
        for (i = 0; i < cap && !broken; i++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                bus_status(ST_ARB_LOST, 8'($urandom));
                broken = 1'b1;
            end
            else
                bus_status((i == cap - 1) ? ST_MR_DAT_NACK : ST_MR_DAT_ACK, 8'($urandom));
        end
        read_seqs++;
    endtask

    task automatic random_slave();
        int i, n;
        bus_status(($urandom_range(0, 9) == 0) ? ST_SR_ARB_LOST : ST_SR_SLA_ACK,
                   8'($urandom));
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        for (i = 0; i < n; i++)
            bus_status(ST_SR_DAT_ACK, 8'($urandom));
        if ($urandom_range(0, 6) == 0)
            bus_status(ST_SR_DAT_NACK, 8'($urandom));
        else
            bus_status(ST_SR_STOP, 8'($urandom));
        if ($urandom_range(0, 9) < 7)
            release_slave();
        slave_seqs++;
    endtask

    task automatic random_noise();
        int i, n;
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++)
            random_command();
        noise_seqs++;
    endtask

    task automatic test_random_phase(input bit en, input logic [7:0] cap,
                                     input bit src_idle, input bit sink_stall);
        int         start, r;
        logic [7:0] en_word;
        wait_results_drained();
        en_word = 8'($urandom);
        en_word[0] = en;
        write_reg(CFG_SLAVE_ENABLE, en_word);
        write_reg(CFG_SLAVE_CAPACITY, cap);
        settings_used++;
        src_idle_on = src_idle;
        sink_stall_on = sink_stall;
        start = beats_sent;
        while (beats_sent - start < PHASE_BEATS)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
                random_send();
            else if (r < 55)
                random_read();
            else if (r < 80)
                random_slave();
            else
                random_noise();
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = '0;
        cmd_ch.status_code = '0;
        cmd_ch.data_byte = '0;
        cmd_ch.peer_address = '0;
        cmd_ch.count = '0;
        cmd_ch.buffer_index = '0;
        src_idle_on = 1'b1;
        sink_stall_on = 1'b1;
        beats_sent = 0;
        results_seen = 0;
        mismatches = 0;
        settings_used = 0;
        send_seqs = 0;
        read_seqs = 0;
        slave_seqs = 0;
        noise_seqs = 0;
        // state after reset
        own_bus = 1'b0;
        hold_nack = 1'b0;
        tx_busy = 1'b0;
        tx_dest = '0;
        tx_len = '0;
        tx_pos = '0;
        rx_open = 1'b0;
        rx_cnt = '0;
        rx_full = 1'b0;
        rd_busy = 1'b0;
        rd_dest = '0;
        rd_cap = '0;
        rd_cnt = '0;
        slave_en_cfg = 1'b0;
        slave_cap_cfg = 8'd32;
        for (int i = 0; i < TXD; i++)
            tx_mem[i[5:0]] = 8'h00;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_master_send();
        test_send_edges();
        test_master_read();
        test_slave_receive();
        test_fill_tx_buffer();

        test_random_phase(1'b1, 8'd32, 1'b1, 1'b1);
        test_random_phase(1'b1, 8'd0, 1'b1, 1'b0);
        test_random_phase(1'b0, 8'd255, 1'b0, 1'b1);
        test_random_phase(1'b1, 8'd255, 1'b0, 1'b0);
        test_random_phase(1'b1, 8'($urandom_range(1, 4)), 1'b1, 1'b1);
        test_random_phase(1'b0, 8'($urandom), 1'b1, 1'b1);
        test_random_phase(1'b1, 8'($urandom_range(1, 8)), 1'b1, 1'b1);
        test_random_phase(1'b1, 8'($urandom_range(2, 12)), 1'b0, 1'b0);

        wait_results_drained();
        repeat (10) @(negedge clk);

        $display("%0d command beats, %0d result beats checked, %0d mismatches",
                 beats_sent, results_seen, mismatches);
        $display("%0d sends, %0d reads, %0d slave packets, %0d noise bursts over %0d settings",
                 send_seqs, read_seqs, slave_seqs, noise_seqs, settings_used);
        if (mismatches == 0 && pending_actions.size() == 0)
            $display("i2c_packet_sequencer_unit_tb passed");
        else
            $display("i2c_packet_sequencer_unit_tb failed");
        $finish;
    end

endmodule
